// ----- rtl/wwc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wwc_pkg: shared types and constants of the weighted window centroid
// Item layouts, register indexes, sequencer states and datapath widths.
// ---------------------------------------------------------------------------
package wwc_pkg;

   localparam int MZ_W       = 28;
   localparam int INT_W      = 20;
   localparam int MOB_W      = 20;
   localparam int TOT_W      = 36;
   localparam int MZ_SUM_W   = 64;
   localparam int MOB_SUM_W  = 56;
   localparam int PROD_W     = MZ_W + INT_W;
   localparam int DIV_NUM_W  = MZ_SUM_W;
   localparam int DIV_DEN_W  = TOT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_MZ_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MZ_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_HIGH   = 3'd4;

   typedef struct packed {
      logic [MZ_W-1:0]  peak_mz;
      logic [INT_W-1:0] peak_intensity;
      logic [MOB_W-1:0] peak_mobility;
      logic             last_peak;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [TOT_W-1:0] total_intensity;
      logic [MZ_W-1:0]  mean_mz;
      logic [MOB_W-1:0] mean_mobility;
      logic             saturated;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_MZ,
      ST_ADD_MZ,
      ST_MUL_MOB,
      ST_ADD_MOB,
      ST_DIV_MZ_GO,
      ST_DIV_MZ_RUN,
      ST_DIV_MOB_GO,
      ST_DIV_MOB_RUN,
      ST_FINISH
   } state_type;

endpackage : wwc_pkg
`default_nettype wire

// ----- rtl/wwc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wwc_div: radix-2 restoring divider
// One quotient bit per cycle; quotient valid when done pulses.
// ---------------------------------------------------------------------------
module wwc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire wwc_pkg::div_cmd_type         cmd,
   output logic                              done,
   output logic [wwc_pkg::DIV_NUM_W-1:0]     quotient
);
   import wwc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_NUM_W-1:0] nq_ff,    nq_in;
   logic [DIV_DEN_W-1:0] rem_ff,   rem_in;
   logic [DIV_DEN_W-1:0] den_ff,   den_in;

   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign shifted = {rem_ff, nq_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      nq_in    = nq_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_NUM_W);
         nq_in    = cmd.dividend;
         rem_in   = '0;
         den_in   = cmd.divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         nq_in    = {nq_ff[DIV_NUM_W-2:0], fits};
         rem_in   = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = nq_ff;

endmodule : wwc_div
`default_nettype wire

// ----- rtl/weighted_window_centroid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// weighted_window_centroid: intensity weighted centroid in an m/z window
// Accumulates gated peaks through one shared multiplier and saturating
// adders; on the last peak divides the sums in a shared serial divider.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  req_data  (wwc_pkg::req_type)
//  rsp_     out        rsp_valid / rsp_stall  rsp_data  (wwc_pkg::rsp_type)
//  csr_     in         csr_we                 csr_index, csr_wdata
//
//  An ordinary peak passes through accept, m/z product, m/z add, mobility
//  product and mobility add; both products use the one 20 x 28 multiplier.
//  A last peak then runs a division in the 64-step divider for m/z and,
//  with gating on, a second for mobility, then loads the output; with a
//  zero intensity sum it skips the divisions and loads the output.
//  Reset clears the sums, the saturation flag, the registers and rsp_valid.
//  The output register holds a result while rsp_stall is high; the next item
//  is taken meanwhile, and a new result waits only if the old is not gone.
// ---------------------------------------------------------------------------
module weighted_window_centroid (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // peak items
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire wwc_pkg::req_type               req_data,
   // result items
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output wwc_pkg::rsp_type                    rsp_data,
   // register writes
   input  wire logic                           csr_we,
   input  wire logic [wwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wwc_pkg::*;

   // sequencer and held item
   state_type              state_ff,     state_in;
   req_type                item_ff,      item_in;
   logic                   counts_ff,    counts_in;
   logic                   gate_ff,      gate_in;
   logic [PROD_W-1:0]      prod_ff,      prod_in;

   // running sums
   logic [TOT_W-1:0]       isum_ff,      isum_in;
   logic [MZ_SUM_W-1:0]    mzsum_ff,     mzsum_in;
   logic [MOB_SUM_W-1:0]   mobsum_ff,    mobsum_in;
   logic                   sat_ff,       sat_in;

   // configuration
   logic [MZ_W-1:0]        mz_low_ff,    mz_low_in;
   logic [MZ_W-1:0]        mz_high_ff,   mz_high_in;
   logic                   im_enable_ff, im_enable_in;
   logic [MOB_W-1:0]       im_low_ff,    im_low_in;
   logic [MOB_W-1:0]       im_high_ff,   im_high_in;

   // results
   logic [MZ_W-1:0]        mean_mz_ff,   mean_mz_in;
   logic [MOB_W-1:0]       mean_mob_ff,  mean_mob_in;
   rsp_type                rsp_ff,       rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath nets
   logic [MZ_W-1:0]        mul_b;
   logic [PROD_W-1:0]      mul_out;
   logic [TOT_W:0]         isum_add;
   logic [MZ_SUM_W:0]      mzsum_add;
   logic [MOB_SUM_W:0]     mobsum_add;
   logic                   win_hit;
   logic                   found;
   div_cmd_type            div_cmd;
   logic                   div_done;
   logic [DIV_NUM_W-1:0]   div_quot;

   // Shared multiplier: intensity times m/z, then times mobility.
   assign mul_b   = (state_ff == ST_MUL_MOB) ?
                    {{(MZ_W-MOB_W){1'b0}}, item_ff.peak_mobility} : item_ff.peak_mz;
   assign mul_out = {{(PROD_W-INT_W){1'b0}}, item_ff.peak_intensity}
                  * {{(PROD_W-MZ_W){1'b0}}, mul_b};

   // Carry out of each add marks saturation.
   assign isum_add   = {1'b0, isum_ff} + {{(TOT_W-INT_W+1){1'b0}}, item_ff.peak_intensity};
   assign mzsum_add  = {1'b0, mzsum_ff} + {{(MZ_SUM_W-PROD_W+1){1'b0}}, prod_ff};
   assign mobsum_add = {1'b0, mobsum_ff}
                     + {{(MOB_SUM_W-MOB_W-INT_W+1){1'b0}}, prod_ff[MOB_W+INT_W-1:0]};

   // Window test against the registers as they stand when the item arrives.
   assign win_hit = (req_data.peak_mz >= mz_low_ff) && (req_data.peak_mz < mz_high_ff)
                 && (!im_enable_ff || ((req_data.peak_mobility >= im_low_ff)
                                    && (req_data.peak_mobility <= im_high_ff)));

   assign found = (isum_ff != '0);

   // The divider always sees the intensity sum as divisor.
   assign div_cmd.start    = (state_ff == ST_DIV_MZ_GO) || (state_ff == ST_DIV_MOB_GO);
   assign div_cmd.dividend = (state_ff == ST_DIV_MOB_GO) ?
                             {{(DIV_NUM_W-MOB_SUM_W){1'b0}}, mobsum_ff} : mzsum_ff;
   assign div_cmd.divisor  = isum_ff;

   wwc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      counts_in    = counts_ff;
      gate_in      = gate_ff;
      prod_in      = prod_ff;
      isum_in      = isum_ff;
      mzsum_in     = mzsum_ff;
      mobsum_in    = mobsum_ff;
      sat_in       = sat_ff;
      mz_low_in    = mz_low_ff;
      mz_high_in   = mz_high_ff;
      im_enable_in = im_enable_ff;
      im_low_in    = im_low_ff;
      im_high_in   = im_high_ff;
      mean_mz_in   = mean_mz_ff;
      mean_mob_in  = mean_mob_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      req_stall = (state_ff != ST_IDLE);

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_MZ_LOW:    mz_low_in    = csr_wdata[MZ_W-1:0];
            CSR_MZ_HIGH:   mz_high_in   = csr_wdata[MZ_W-1:0];
            CSR_IM_ENABLE: im_enable_in = csr_wdata[0];
            CSR_IM_LOW:    im_low_in    = csr_wdata[MOB_W-1:0];
            CSR_IM_HIGH:   im_high_in   = csr_wdata[MOB_W-1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_data;
               counts_in = win_hit;
               gate_in   = im_enable_ff;
               state_in  = ST_MUL_MZ;
            end
         end
         ST_MUL_MZ: begin
            prod_in  = mul_out;
            state_in = ST_ADD_MZ;
         end
         ST_ADD_MZ: begin
            if (counts_ff) begin
               if (isum_add[TOT_W]) begin
                  isum_in = '1;
                  sat_in  = 1'b1;
               end else begin
                  isum_in = isum_add[TOT_W-1:0];
               end
               if (mzsum_add[MZ_SUM_W]) begin
                  mzsum_in = '1;
                  sat_in   = 1'b1;
               end else begin
                  mzsum_in = mzsum_add[MZ_SUM_W-1:0];
               end
            end
            state_in = ST_MUL_MOB;
         end
         ST_MUL_MOB: begin
            prod_in  = mul_out;
            state_in = ST_ADD_MOB;
         end
         ST_ADD_MOB: begin
            if (counts_ff && gate_ff) begin
               if (mobsum_add[MOB_SUM_W]) begin
                  mobsum_in = '1;
                  sat_in    = 1'b1;
               end else begin
                  mobsum_in = mobsum_add[MOB_SUM_W-1:0];
               end
            end
            // means read as zero unless a division fills them
            mean_mz_in  = '0;
            mean_mob_in = '0;
            if (!item_ff.last_peak) begin
               state_in = ST_IDLE;
            end else if (found) begin
               state_in = ST_DIV_MZ_GO;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_MZ_GO: begin
            state_in = ST_DIV_MZ_RUN;
         end
         ST_DIV_MZ_RUN: begin
            if (div_done) begin
               // clamp to the field maximum
               mean_mz_in = (div_quot[DIV_NUM_W-1:MZ_W] != '0) ? '1 : div_quot[MZ_W-1:0];
               state_in   = gate_ff ? ST_DIV_MOB_GO : ST_FINISH;
            end
         end
         ST_DIV_MOB_GO: begin
            state_in = ST_DIV_MOB_RUN;
         end
         ST_DIV_MOB_RUN: begin
            if (div_done) begin
               mean_mob_in = (div_quot[DIV_NUM_W-1:MOB_W] != '0) ? '1 : div_quot[MOB_W-1:0];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.found           = found;
               rsp_in.total_intensity = isum_ff;
               rsp_in.mean_mz         = mean_mz_ff;
               rsp_in.mean_mobility   = mean_mob_ff;
               rsp_in.saturated       = sat_ff;
               rsp_valid_in           = 1'b1;
               isum_in                = '0;
               mzsum_in               = '0;
               mobsum_in              = '0;
               sat_in                 = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         isum_ff      <= '0;
         mzsum_ff     <= '0;
         mobsum_ff    <= '0;
         sat_ff       <= 1'b0;
         mz_low_ff    <= '0;
         mz_high_ff   <= '0;
         im_enable_ff <= 1'b0;
         im_low_ff    <= '0;
         im_high_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         isum_ff      <= isum_in;
         mzsum_ff     <= mzsum_in;
         mobsum_ff    <= mobsum_in;
         sat_ff       <= sat_in;
         mz_low_ff    <= mz_low_in;
         mz_high_ff   <= mz_high_in;
         im_enable_ff <= im_enable_in;
         im_low_ff    <= im_low_in;
         im_high_ff   <= im_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      counts_ff   <= counts_in;
      gate_ff     <= gate_in;
      prod_ff     <= prod_in;
      mean_mz_ff  <= mean_mz_in;
      mean_mob_ff <= mean_mob_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : weighted_window_centroid
`default_nettype wire
